[hw/rtl/nv12sc_pkg.sv]
// ----------------------------------------------------------------------------
// nv12sc_pkg
// Shared types and constants of the nearest-neighbor NV12 scaler: store
// geometry, register indexes, result status codes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nv12sc_pkg;

  // store and frame geometry
  localparam int STORE_BYTES = 65536;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = 13;
  localparam int COORD_W     = 12;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int DIV_STEPS   = DIM_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W   = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_SRC_STRIDE = 3'd2,
    CFG_DST_WIDTH  = 3'd3,
    CFG_DST_HEIGHT = 3'd4
  } cfg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CFG_ERR   = 2'd1,
    ST_RANGE_ERR = 2'd2
  } status_t;

  // input command codes
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  // operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    MUL_BASE, // stride * source height
    MUL_ROW,  // target row * source rows of the plane
    MUL_COL,  // target column * source columns of the plane
    MUL_ADDR  // mapped row * stride
  } mul_sel_t;

  // divisor choice of the shared divider
  typedef enum logic {
    DIV_ROWS = 1'b0,
    DIV_COLS = 1'b1
  } div_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     wr_en;
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     chk_eval;
    logic     div_load;
    div_sel_t div_sel;
    logic     div_step;
    logic     row_save;
    logic     mem_rd;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;
  } dp_stat_t;

endpackage

[hw/rtl/nv12_nearest_neighbor_scaler_top.sv]
// Write beats give no result; a new command may follow at once. Read beats run the
// base product, the check, the row and column divisions of the shared restoring
// divider, the address build and the store read before the strobe; a bad config or
// coordinate ends the read at the check. No command is taken during a read; start is
// taken again in the cycle of the strobe. Synchronous active-low reset clears control
// and configuration; the frame store is not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
// nv12_nearest_neighbor_scaler_top
// Nearest-neighbor NV12 scaler: holds a source frame in a byte store and
// returns bytes of the scaled target frame on request.
// ----------------------------------------------------------------------------
module nv12_nearest_neighbor_scaler_top
  import nv12sc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  // command
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_cmd,
  input  logic [ADDR_W-1:0]    in_src_addr,
  input  logic [7:0]           in_src_byte,
  input  logic                 in_plane,
  input  logic [COORD_W-1:0]   in_out_x,
  input  logic [COORD_W-1:0]   in_out_y,
  input  logic                 in_component,
  // result
  output logic                 out_valid,
  output logic [7:0]           out_pixel_byte,
  output logic [1:0]           out_status
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer
  nv12sc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  // datapath
  nv12sc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_src_addr    (in_src_addr),
    .in_src_byte    (in_src_byte),
    .in_plane       (in_plane),
    .in_out_x       (in_out_x),
    .in_out_y       (in_out_y),
    .in_component   (in_component),
    .dp_cmd         (dp_cmd),
    .dp_stat        (dp_stat),
    .out_pixel_byte (out_pixel_byte),
    .out_status     (out_status)
  );

endmodule

[hw/rtl/nv12sc_ctrl.sv]
// ----------------------------------------------------------------------------
// nv12sc_ctrl
// Sequencer of the scaler: accepts commands, steps the datapath through the
// configuration check, two divisions and the address build, and raises the
// result strobe.
// ----------------------------------------------------------------------------
module nv12sc_ctrl
  import nv12sc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_cmd,
  output logic     busy,
  output logic     out_valid,
  output dp_cmd_t  dp_cmd,
  input  dp_stat_t dp_stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_CHECK,
    S_LOAD_ROW,
    S_DIV_ROW,
    S_MUL_COL,
    S_LOAD_COL,
    S_DIV_COL,
    S_ADDR,
    S_READ
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic               accept;
  logic               last_step;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = start && (state_r == S_IDLE);
  assign last_step = (cnt_r == CNT_W'(DIV_STEPS - 1));

  // state, step counter and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && (cmd_t'(in_cmd) == CMD_READ)) begin
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (dp_stat.err) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= S_LOAD_ROW;
          end
        end
        S_LOAD_ROW: begin
          cnt_r   <= '0;
          state_r <= S_DIV_ROW;
        end
        S_DIV_ROW: begin
          cnt_r <= cnt_r + 1'b1;
          if (last_step) begin
            state_r <= S_MUL_COL;
          end
        end
        S_MUL_COL: begin
          state_r <= S_LOAD_COL;
        end
        S_LOAD_COL: begin
          cnt_r   <= '0;
          state_r <= S_DIV_COL;
        end
        S_DIV_COL: begin
          cnt_r <= cnt_r + 1'b1;
          if (last_step) begin
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          state_r <= S_READ;
        end
        S_READ: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // datapath commands decoded from state
  always_comb begin
    dp_cmd          = '0;
    dp_cmd.mul_sel  = MUL_BASE;
    dp_cmd.div_sel  = DIV_ROWS;
    dp_cmd.wr_en    = accept && (cmd_t'(in_cmd) == CMD_WRITE);
    dp_cmd.capture  = accept && (cmd_t'(in_cmd) == CMD_READ);
    unique case (state_r)
      S_BASE: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_BASE;
      end
      S_CHECK: begin
        dp_cmd.chk_eval = 1'b1;
        dp_cmd.mul_en   = 1'b1;
        dp_cmd.mul_sel  = MUL_ROW;
      end
      S_LOAD_ROW: begin
        dp_cmd.div_load = 1'b1;
        dp_cmd.div_sel  = DIV_ROWS;
      end
      S_DIV_ROW, S_DIV_COL: begin
        dp_cmd.div_step = 1'b1;
      end
      S_MUL_COL: begin
        dp_cmd.row_save = 1'b1;
        dp_cmd.mul_en   = 1'b1;
        dp_cmd.mul_sel  = MUL_COL;
      end
      S_LOAD_COL: begin
        dp_cmd.div_load = 1'b1;
        dp_cmd.div_sel  = DIV_COLS;
      end
      S_ADDR: begin
        dp_cmd.mul_en  = 1'b1;
        dp_cmd.mul_sel = MUL_ADDR;
      end
      S_READ: begin
        dp_cmd.mem_rd = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/nv12sc_dpath.sv]
// ----------------------------------------------------------------------------
// nv12sc_dpath
// Datapath of the scaler: configuration registers, frame store, one shared
// multiplier, one radix-2 restoring divider and the result registers.
// ----------------------------------------------------------------------------
module nv12sc_dpath
  import nv12sc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]   cfg_wdata,
  input  logic [ADDR_W-1:0]  in_src_addr,
  input  logic [7:0]         in_src_byte,
  input  logic               in_plane,
  input  logic [COORD_W-1:0] in_out_x,
  input  logic [COORD_W-1:0] in_out_y,
  input  logic               in_component,
  input  dp_cmd_t            dp_cmd,
  output dp_stat_t           dp_stat,
  output logic [7:0]         out_pixel_byte,
  output logic [1:0]         out_status
);

  // configuration
  logic [DIM_W-1:0] src_width_r, src_height_r, src_stride_r;
  logic [DIM_W-1:0] dst_width_r, dst_height_r;

  // captured read item
  logic               plane_r;
  logic               comp_r;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;

  // arithmetic
  logic [PROD_W-1:0]  base_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DIM_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [DIM_W-1:0]   divisor_r;
  logic [DIM_W-1:0]   rem_r;
  logic [DIM_W-1:0]   dvd_r;
  logic [DIM_W-1:0]   quo_r;
  logic [DIM_W-1:0]   row_r;
  logic [DIM_W:0]     trial;
  logic               q_bit;

  // plane-scaled sizes
  logic [DIM_W-1:0]   src_w_pl, src_h_pl, dst_w_pl, dst_h_pl;

  // check
  logic [PROD_W:0]    need3;
  logic               cfg_ok;
  logic               coord_ok;

  // store and result
  logic [7:0]         mem_r [STORE_BYTES];
  logic [PROD_W+1:0]  addr_sum;
  logic [7:0]         pix_r;
  status_t            status_r;

  function automatic logic size_ok(input logic [DIM_W-1:0] v);
    return (v != '0) && !v[0] && (v <= DIM_W'(MAX_DIM));
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= '0;
      src_height_r <= '0;
      src_stride_r <= '0;
      dst_width_r  <= '0;
      dst_height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        CFG_SRC_STRIDE: src_stride_r <= cfg_wdata;
        CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata;
        CFG_DST_HEIGHT: dst_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // capture the read item
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      plane_r <= in_plane;
      comp_r  <= in_component;
      x_r     <= in_out_x;
      y_r     <= in_out_y;
    end
  end

  // chroma works on half-size planes
  assign src_w_pl = plane_r ? (src_width_r  >> 1) : src_width_r;
  assign src_h_pl = plane_r ? (src_height_r >> 1) : src_height_r;
  assign dst_w_pl = plane_r ? (dst_width_r  >> 1) : dst_width_r;
  assign dst_h_pl = plane_r ? (dst_height_r >> 1) : dst_height_r;

  // shared multiplier operands
  always_comb begin
    unique case (dp_cmd.mul_sel)
      MUL_BASE: begin
        mul_a = src_stride_r;
        mul_b = src_height_r;
      end
      MUL_ROW: begin
        mul_a = {1'b0, y_r};
        mul_b = src_h_pl;
      end
      MUL_COL: begin
        mul_a = {1'b0, x_r};
        mul_b = src_w_pl;
      end
      MUL_ADDR: begin
        mul_a = row_r;
        mul_b = src_stride_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (dp_cmd.mul_en) begin
      if (dp_cmd.mul_sel == MUL_BASE) begin
        base_r <= mul_p;
      end else begin
        prod_r <= mul_p;
      end
    end
  end

  // configuration and coordinate check; frame needs stride*height*3/2 bytes
  assign need3  = {1'b0, base_r} + {2'b00, base_r[PROD_W-1:1]};
  assign cfg_ok = size_ok(src_width_r) && size_ok(src_height_r) &&
                  size_ok(dst_width_r) && size_ok(dst_height_r) &&
                  (src_stride_r >= src_width_r) &&
                  (need3 <= (PROD_W+1)'(STORE_BYTES));
  assign coord_ok = ({1'b0, x_r} < dst_w_pl) && ({1'b0, y_r} < dst_h_pl);
  assign dp_stat.err = !cfg_ok || !coord_ok;

  // restoring divider, one quotient bit per cycle; quotient fits DIM_W bits
  assign trial = {rem_r, dvd_r[DIM_W-1]};
  assign q_bit = (trial >= {1'b0, divisor_r});

  always_ff @(posedge clk) begin
    if (dp_cmd.div_load) begin
      divisor_r <= (dp_cmd.div_sel == DIV_COLS) ? dst_w_pl : dst_h_pl;
      rem_r     <= prod_r[PROD_W-1:DIM_W];
      dvd_r     <= prod_r[DIM_W-1:0];
      quo_r     <= '0;
    end else if (dp_cmd.div_step) begin
      rem_r <= q_bit ? DIM_W'(trial - {1'b0, divisor_r}) : trial[DIM_W-1:0];
      dvd_r <= {dvd_r[DIM_W-2:0], 1'b0};
      quo_r <= {quo_r[DIM_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.row_save) begin
      row_r <= quo_r;
    end
  end

  // byte address: luma row*stride+col, chroma adds the luma plane size
  assign addr_sum = plane_r
    ? ((PROD_W+2)'(prod_r) + (PROD_W+2)'(base_r) +
       (PROD_W+2)'({quo_r, 1'b0}) + (PROD_W+2)'(comp_r))
    : ((PROD_W+2)'(prod_r) + (PROD_W+2)'(quo_r));

  // frame store write port
  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en) begin
      mem_r[in_src_addr] <= in_src_byte;
    end
  end

  // frame store read port and result registers
  always_ff @(posedge clk) begin
    if (dp_cmd.mem_rd) begin
      if (addr_sum < (PROD_W+2)'(STORE_BYTES)) begin
        pix_r <= mem_r[addr_sum[ADDR_W-1:0]];
      end else begin
        pix_r <= '0;
      end
    end else if (dp_cmd.chk_eval && dp_stat.err) begin
      pix_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.chk_eval) begin
      priority if (!cfg_ok) begin
        status_r <= ST_CFG_ERR;
      end else if (!coord_ok) begin
        status_r <= ST_RANGE_ERR;
      end else begin
        status_r <= ST_OK;
      end
    end
  end

  assign out_pixel_byte = pix_r;
  assign out_status     = status_r;

endmodule

[hw/rtl/nv12sc_checker.sv]
// ----------------------------------------------------------------------------
// nv12sc_checker
// Port-level checks of the scaler, bound to the top level.
// ----------------------------------------------------------------------------
module nv12sc_checker
  import nv12sc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_cmd,
  input logic       out_valid,
  input logic [7:0] out_pixel_byte,
  input logic [1:0] out_status
);

  // reset leaves the block idle with no result beat
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or out_valid after reset");

  // a result beat lasts one cycle
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat longer than one cycle");

  // an accepted read occupies the block, a write does not
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == CMD_READ) |=> busy && !out_valid)
    else $error("read not in progress after acceptance");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == CMD_WRITE) |=> !busy && !out_valid)
    else $error("write left the block busy or made a result");

  // error results carry a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_pixel_byte == 8'd0) && !busy)
    else $error("error result with nonzero byte");

endmodule

bind nv12_nearest_neighbor_scaler_top nv12sc_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_pixel_byte (out_pixel_byte),
  .out_status     (out_status)
);
